/* rtl/btce_pkg.sv */
`timescale 1ns / 1ps

package btce_pkg;

	// field widths
	localparam int TEMP_W     = 12;
	localparam int SENSORS    = 5;
	localparam int SUM_W      = 15;
	localparam int CNT_W      = 3;
	localparam int NUM_W      = 16;
	localparam int SPAN_W     = 13;
	localparam int VOL_W      = 14;
	localparam int CHG_W      = 10;
	localparam int NRG_W      = 21;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_TEMP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_TEMP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME     = 2'd3;

	localparam int EMPTY_TEMP_RST = 300;
	localparam int FULL_TEMP_RST  = 800;
	localparam int VOLUME_RST     = 500;

	// arithmetic constants
	localparam int REF_TEMP       = 300;      // 30.0 degC in tenths
	localparam int ALARM_MARGIN   = 80;       // 8 K in tenths
	localparam int CHARGE_FULL    = 1000;
	localparam int ENERGY_MAX     = 1750000;
	localparam int WATER_WH_MILLI = 1163;
	localparam int ENERGY_DIV     = 10000;

	// serial divider sizing
	localparam int QE_BITS  = 22;
	localparam int QC_BITS  = 10;
	localparam int STEP_W   = 5;
	localparam int VHEAT_W  = 25;
	localparam int PROD_W   = 39;
	localparam int DEN_C_W  = 15;
	localparam int DEN_E_W  = 16;
	localparam int RC_W     = 25;
	localparam int DC_W     = DEN_C_W + QC_BITS - 1;
	localparam int DE_W     = DEN_E_W + QE_BITS - 1;

	typedef logic signed [TEMP_W-1:0] temp_t;

	typedef struct packed {
		logic              enable;
		temp_t             empty_temp;
		temp_t             full_temp;
		logic [VOL_W-1:0]  volume_litres;
	} cfg_t;

	typedef struct packed {
		temp_t temp_top;
		temp_t temp_upper_mid;
		temp_t temp_mid;
		temp_t temp_lower_mid;
		temp_t temp_bottom;
		logic  top_ok;
		logic  upper_mid_ok;
		logic  mid_ok;
		logic  lower_mid_ok;
		logic  bottom_ok;
	} sample_t;

	typedef struct packed {
		logic [CHG_W-1:0] charge_permille;
		logic [NRG_W-1:0] energy_wh;
		logic             overtemp_alarm;
		logic             no_valid_reading;
	} result_t;

	typedef struct packed {
		logic load;
		logic prep1;
		logic prep2;
		logic step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

/* rtl/btce_ifs.sv */
`timescale 1ns / 1ps

interface btce_sample_if;
	import btce_pkg::*;

	logic  valid;
	logic  ready;
	temp_t temp_top;
	temp_t temp_upper_mid;
	temp_t temp_mid;
	temp_t temp_lower_mid;
	temp_t temp_bottom;
	logic  top_ok;
	logic  upper_mid_ok;
	logic  mid_ok;
	logic  lower_mid_ok;
	logic  bottom_ok;

	modport source (output valid, temp_top, temp_upper_mid, temp_mid, temp_lower_mid,
		temp_bottom, top_ok, upper_mid_ok, mid_ok, lower_mid_ok, bottom_ok, input ready);
	modport sink (input valid, temp_top, temp_upper_mid, temp_mid, temp_lower_mid,
		temp_bottom, top_ok, upper_mid_ok, mid_ok, lower_mid_ok, bottom_ok, output ready);
endinterface

interface btce_result_if;
	import btce_pkg::*;

	logic             valid;
	logic             ready;
	logic [CHG_W-1:0] charge_permille;
	logic [NRG_W-1:0] energy_wh;
	logic             overtemp_alarm;
	logic             no_valid_reading;

	modport source (output valid, charge_permille, energy_wh, overtemp_alarm,
		no_valid_reading, input ready);
	modport sink (input valid, charge_permille, energy_wh, overtemp_alarm,
		no_valid_reading, output ready);
endinterface

interface btce_cfg_if;
	import btce_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/btce_ctrl.sv */
`timescale 1ns / 1ps

module btce_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  enable,
	input  btce_pkg::ctrl_sts_t   sts,
	output logic                  in_ready,
	output btce_pkg::ctrl_cmd_t   cmd
);
	import btce_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP1 = 3'd1;
	localparam logic [2:0] ST_PREP2 = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// items taken while disabled are dropped
				if (in_valid && enable) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP1;
				end
			end
			ST_PREP1: begin
				cmd.prep1 = 1'b1;
				state_d   = ST_PREP2;
			end
			ST_PREP2: begin
				cmd.prep2 = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/btce_dp.sv */
`timescale 1ns / 1ps

module btce_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  btce_pkg::cfg_t       cfg,
	input  btce_pkg::sample_t    smp,
	input  btce_pkg::ctrl_cmd_t  cmd,
	output btce_pkg::ctrl_sts_t  sts,
	input  logic                 out_ready,
	output logic                 out_valid,
	output btce_pkg::result_t    res
);
	import btce_pkg::*;

	// snapshot reduction
	temp_t                   temps [SENSORS];
	logic [SENSORS-1:0]      oks;
	logic signed [SUM_W-1:0] sum_c;
	logic [CNT_W-1:0]        n_c;

	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        n_q;
	temp_t                   top_q;
	logic                    top_ok_q;

	// first prep stage
	logic signed [NUM_W-1:0]  n_s;
	logic signed [NUM_W-1:0]  empty_s;
	logic signed [NUM_W-1:0]  sum_s;
	logic signed [NUM_W-1:0]  n_ref_s;
	logic signed [SPAN_W-1:0] span_c;

	logic signed [NUM_W-1:0]  num_q;
	logic                     span_pos_q;
	logic [DEN_C_W-1:0]       den_c_q;
	logic signed [NUM_W-1:0]  dk_q;
	logic [VHEAT_W-1:0]       vheat_q;
	logic [DEN_E_W-1:0]       den_e_q;

	// second prep stage and divider
	logic                 num_pos;
	logic                 dk_pos;
	logic [RC_W-1:0]      rc_q;
	logic [DC_W-1:0]      dc_q;
	logic [PROD_W-1:0]    re_q;
	logic [DE_W-1:0]      de_q;
	logic [QC_BITS-1:0]   qc_q;
	logic [QE_BITS-1:0]   qe_q;
	logic [STEP_W-1:0]    k_q;
	logic                 chg_zero_q;
	logic                 chg_sat_q;
	logic                 dk_pos_q;
	logic                 e_ge;
	logic                 c_ge;

	// result
	logic signed [SPAN_W-1:0] alarm_lim;
	logic signed [SPAN_W-1:0] top_s;
	logic                     alarm_hit;
	logic                     alarm_q;
	logic                     alarm_d;
	logic                     out_valid_q;
	result_t                  res_q;
	result_t                  res_d;

	always_comb begin
		temps[0] = smp.temp_top;
		temps[1] = smp.temp_upper_mid;
		temps[2] = smp.temp_mid;
		temps[3] = smp.temp_lower_mid;
		temps[4] = smp.temp_bottom;
		oks      = {smp.bottom_ok, smp.lower_mid_ok, smp.mid_ok, smp.upper_mid_ok, smp.top_ok};
		sum_c    = '0;
		n_c      = '0;
		for (int i = 0; i < SENSORS; i++) begin
			if (oks[i]) begin
				sum_c = sum_c + SUM_W'(temps[i]);
				n_c   = n_c + CNT_W'(1);
			end
		end
	end

	assign n_s     = {{(NUM_W-CNT_W){1'b0}}, n_q};
	assign empty_s = NUM_W'(cfg.empty_temp);
	assign sum_s   = NUM_W'(sum_q);
	assign n_ref_s = n_s * NUM_W'(REF_TEMP);
	assign span_c  = SPAN_W'(cfg.full_temp) - SPAN_W'(cfg.empty_temp);

	assign num_pos = !num_q[NUM_W-1] && (num_q != '0);
	assign dk_pos  = !dk_q[NUM_W-1] && (dk_q != '0);

	assign e_ge = re_q >= PROD_W'(de_q);
	assign c_ge = rc_q >= RC_W'(dc_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q    <= sum_c;
			n_q      <= n_c;
			top_q    <= smp.temp_top;
			top_ok_q <= smp.top_ok;
		end
		if (cmd.prep1) begin
			num_q      <= sum_s - n_s * empty_s;
			span_pos_q <= !span_c[SPAN_W-1] && (span_c != '0);
			den_c_q    <= DEN_C_W'(n_q) * DEN_C_W'(span_c[SPAN_W-2:0]);
			dk_q       <= sum_s - n_ref_s;
			vheat_q    <= VHEAT_W'(cfg.volume_litres) * VHEAT_W'(WATER_WH_MILLI);
			den_e_q    <= DEN_E_W'(n_q) * DEN_E_W'(ENERGY_DIV);
		end
		if (cmd.prep2) begin
			chg_zero_q <= !(span_pos_q && num_pos);
			chg_sat_q  <= NUM_W'(num_q) >= NUM_W'(den_c_q);
			dk_pos_q   <= dk_pos;
			rc_q       <= num_pos ? RC_W'(num_q[NUM_W-2:0]) * RC_W'(CHARGE_FULL) : '0;
			dc_q       <= {den_c_q, {(QC_BITS-1){1'b0}}};
			re_q       <= dk_pos ? PROD_W'(vheat_q) * PROD_W'(dk_q[NUM_W-2:0]) : '0;
			de_q       <= {den_e_q, {(QE_BITS-1){1'b0}}};
			k_q        <= STEP_W'(QE_BITS-1);
			qc_q       <= '0;
			qe_q       <= '0;
		end else if (cmd.step) begin
			// restoring division, one quotient bit per cycle
			if (e_ge) begin
				re_q <= re_q - PROD_W'(de_q);
			end
			qe_q <= {qe_q[QE_BITS-2:0], e_ge};
			de_q <= de_q >> 1;
			k_q  <= k_q - STEP_W'(1);
			if (k_q < STEP_W'(QC_BITS)) begin
				if (c_ge) begin
					rc_q <= rc_q - RC_W'(dc_q);
				end
				qc_q <= {qc_q[QC_BITS-2:0], c_ge};
				dc_q <= dc_q >> 1;
			end
		end
	end

	assign sts.div_last = (k_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	assign alarm_lim = SPAN_W'(cfg.full_temp) + SPAN_W'(ALARM_MARGIN);
	assign top_s     = SPAN_W'(top_q);
	assign alarm_hit = top_ok_q && (top_s > alarm_lim);
	assign alarm_d   = (n_q != '0) ? alarm_hit : alarm_q;

	always_comb begin
		res_d.no_valid_reading = (n_q == '0);
		res_d.overtemp_alarm   = alarm_d;
		if (chg_zero_q) begin
			res_d.charge_permille = '0;
		end else if (chg_sat_q) begin
			res_d.charge_permille = CHG_W'(CHARGE_FULL);
		end else begin
			res_d.charge_permille = qc_q;
		end
		if (!dk_pos_q) begin
			res_d.energy_wh = '0;
		end else if (qe_q > QE_BITS'(ENERGY_MAX)) begin
			res_d.energy_wh = NRG_W'(ENERGY_MAX);
		end else begin
			res_d.energy_wh = qe_q[NRG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				alarm_q     <= alarm_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

/* rtl/buffer_tank_charge_estimator.sv */
`timescale 1ns / 1ps
// an accepted item is captured, prepared in prep1 and prep2, divided, then written to the output register
// a new item is taken only once the previous one has left the 22-step serial divider and been written back
// items accepted while disabled are dropped and give no result
// a waiting result does not stop the next item from being computed
// arst_n clears the controller, the alarm, the output valid and loads register defaults

module buffer_tank_charge_estimator (
	input  logic          clk,
	input  logic          arst_n,
	btce_sample_if.sink   sample,
	btce_result_if.source result,
	btce_cfg_if.sink      cfg
);
	import btce_pkg::*;

	cfg_t      cfg_q;
	sample_t   smp;
	result_t   res;
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	logic      in_ready;
	logic      out_valid;

	// register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b0;
			cfg_q.empty_temp    <= TEMP_W'(EMPTY_TEMP_RST);
			cfg_q.full_temp     <= TEMP_W'(FULL_TEMP_RST);
			cfg_q.volume_litres <= VOL_W'(VOLUME_RST);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ENABLE:     cfg_q.enable        <= cfg.data[0];
				REG_EMPTY_TEMP: cfg_q.empty_temp    <= cfg.data[TEMP_W-1:0];
				REG_FULL_TEMP:  cfg_q.full_temp     <= cfg.data[TEMP_W-1:0];
				REG_VOLUME:     cfg_q.volume_litres <= cfg.data[VOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// gather the snapshot item
	assign smp.temp_top       = sample.temp_top;
	assign smp.temp_upper_mid = sample.temp_upper_mid;
	assign smp.temp_mid       = sample.temp_mid;
	assign smp.temp_lower_mid = sample.temp_lower_mid;
	assign smp.temp_bottom    = sample.temp_bottom;
	assign smp.top_ok         = sample.top_ok;
	assign smp.upper_mid_ok   = sample.upper_mid_ok;
	assign smp.mid_ok         = sample.mid_ok;
	assign smp.lower_mid_ok   = sample.lower_mid_ok;
	assign smp.bottom_ok      = sample.bottom_ok;

	assign sample.ready = in_ready;

	// sequencer: capture, prep1 and prep2, divide, write back
	btce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.enable   (cfg_q.enable),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// averaging arithmetic, serial charge and energy divisions, alarm and output register
	btce_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.smp       (smp),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (result.ready),
		.out_valid (out_valid),
		.res       (res)
	);

	assign result.valid            = out_valid;
	assign result.charge_permille  = res.charge_permille;
	assign result.energy_wh        = res.energy_wh;
	assign result.overtemp_alarm   = res.overtemp_alarm;
	assign result.no_valid_reading = res.no_valid_reading;

endmodule

/* tb/sv/buffer_tank_charge_estimator_tb.sv */
`timescale 1ns / 1ps

module buffer_tank_charge_estimator_tb;
	import btce_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;      // longer than an accepted item takes to reach the output register
	localparam int HOLD_CYCLES   = 600;     // long receiver hold-off
	localparam int PHASE_ITEMS   = 225;     // eight random phases, about 1800 items

	// predicted readouts of the tank, kept in acceptance order
	class tank_readout_board;
		cfg_t        regs;
		logic        alarm_on;
		result_t     tank_readouts[$];
		int unsigned errors;

		function new();
			regs.enable        = 1'b0;
			regs.empty_temp    = temp_t'(EMPTY_TEMP_RST);
			regs.full_temp     = temp_t'(FULL_TEMP_RST);
			regs.volume_litres = VOL_W'(VOLUME_RST);
			alarm_on = 1'b0;
			errors   = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_ENABLE:     regs.enable        = val[0];
				REG_EMPTY_TEMP: regs.empty_temp    = temp_t'(val[TEMP_W-1:0]);
				REG_FULL_TEMP:  regs.full_temp     = temp_t'(val[TEMP_W-1:0]);
				REG_VOLUME:     regs.volume_litres = val[VOL_W-1:0];
				default: ;
			endcase
		endfunction

		// average the valid readings and derive charge, energy and alarm
		function void note_snapshot(input sample_t s);
			temp_t   t[SENSORS];
			logic    ok[SENSORS];
			longint  sum, n, span, num, dk, q;
			result_t r;
			if (!regs.enable)
				return;
			t  = '{s.temp_top, s.temp_upper_mid, s.temp_mid, s.temp_lower_mid, s.temp_bottom};
			ok = '{s.top_ok, s.upper_mid_ok, s.mid_ok, s.lower_mid_ok, s.bottom_ok};
			sum = 0;
			n   = 0;
			for (int i = 0; i < SENSORS; i++) begin
				if (ok[i]) begin
					sum += longint'(t[i]);
					n++;
				end
			end
			r = '0;
			r.no_valid_reading = (n == 0);
			if (n > 0) begin
				span = longint'(regs.full_temp) - longint'(regs.empty_temp);
				num  = sum - n * longint'(regs.empty_temp);
				if (span > 0 && num > 0) begin
					q = (num * CHARGE_FULL) / (n * span);
					r.charge_permille = CHG_W'((q > CHARGE_FULL) ? CHARGE_FULL : q);
				end
				dk = sum - n * REF_TEMP;
				if (dk > 0) begin
					q = (longint'(regs.volume_litres) * WATER_WH_MILLI * dk) / (ENERGY_DIV * n);
					r.energy_wh = NRG_W'((q > ENERGY_MAX) ? ENERGY_MAX : q);
				end
				alarm_on = s.top_ok && (longint'(s.temp_top) > longint'(regs.full_temp) + ALARM_MARGIN);
			end
			// no valid reading leaves the alarm as it was
			r.overtemp_alarm = alarm_on;
			tank_readouts.push_back(r);
		endfunction

		function void check_readout(input result_t got);
			result_t want;
			if (tank_readouts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected readout chg=%0d wh=%0d alarm=%0b none=%0b", $realtime,
						got.charge_permille, got.energy_wh, got.overtemp_alarm, got.no_valid_reading);
				return;
			end
			want = tank_readouts.pop_front();
			if (got.charge_permille !== want.charge_permille || got.energy_wh !== want.energy_wh ||
					got.overtemp_alarm !== want.overtemp_alarm ||
					got.no_valid_reading !== want.no_valid_reading) begin
				errors++;
				if (errors <= 10)
					$display("%0t: readout mismatch exp chg=%0d wh=%0d alarm=%0b none=%0b, got chg=%0d wh=%0d alarm=%0b none=%0b",
						$realtime, want.charge_permille, want.energy_wh, want.overtemp_alarm,
						want.no_valid_reading, got.charge_permille, got.energy_wh,
						got.overtemp_alarm, got.no_valid_reading);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	btce_sample_if sample_ch ();
	btce_result_if result_ch ();
	btce_cfg_if    cfg_ch ();

	buffer_tank_charge_estimator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	tank_readout_board board = new();

	// idling percentages, changed between phases
	int unsigned src_idle_pct  = 0;
	int unsigned sink_stall_pct = 0;
	// toggling hold_req starts one long receiver hold-off
	logic        hold_req = 1'b0;
	logic        hold_off;
	int unsigned cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// hold-off counter, in its own process
	initial begin
		hold_off <= 1'b0;
		forever begin
			@(hold_req);
			@(negedge clk);
			hold_off <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_off <= 1'b0;
		end
	end

	// receiver: ready changes on the falling edge, stalls at random or during hold-off
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= !hold_off && !($urandom_range(99) < sink_stall_pct);
		end
	end

	// every accepted readout goes to the scoreboard
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready)
			board.check_readout('{charge_permille: result_ch.charge_permille,
				energy_wh: result_ch.energy_wh, overtemp_alarm: result_ch.overtemp_alarm,
				no_valid_reading: result_ch.no_valid_reading});
	end

	// puts a snapshot and a valid level on the input channel
	task automatic put_snapshot(input sample_t s, input logic v);
		sample_ch.valid          <= v;
		sample_ch.temp_top       <= s.temp_top;
		sample_ch.temp_upper_mid <= s.temp_upper_mid;
		sample_ch.temp_mid       <= s.temp_mid;
		sample_ch.temp_lower_mid <= s.temp_lower_mid;
		sample_ch.temp_bottom    <= s.temp_bottom;
		sample_ch.top_ok         <= s.top_ok;
		sample_ch.upper_mid_ok   <= s.upper_mid_ok;
		sample_ch.mid_ok         <= s.mid_ok;
		sample_ch.lower_mid_ok   <= s.lower_mid_ok;
		sample_ch.bottom_ok      <= s.bottom_ok;
	endtask

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_snapshot(input sample_t s);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		put_snapshot(s, 1'b1);
		do @(posedge clk); while (!sample_ch.ready);
		board.note_snapshot(s);
		@(negedge clk);
	endtask

	// writes all four registers back to back, only while the block is idle
	task automatic apply_setting(input logic en, input int empty_t, input int full_t, input int vol);
		logic [CFG_IDX_W-1:0]  idxs[4];
		logic [CFG_DATA_W-1:0] vals[4];
		idxs = '{REG_ENABLE, REG_EMPTY_TEMP, REG_FULL_TEMP, REG_VOLUME};
		vals = '{CFG_DATA_W'(en), CFG_DATA_W'(empty_t), CFG_DATA_W'(full_t), CFG_DATA_W'(vol)};
		for (int i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idxs[i];
			cfg_ch.data  <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
			board.set_reg(idxs[i], vals[i]);
			@(negedge clk);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// wait for every predicted readout, then settle so that a result from a dropped item would show
	task automatic drain();
		while (board.tank_readouts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ok bits ordered top down to bottom
	function automatic sample_t snap(input int a, input int b, input int c, input int d,
			input int e, input logic [4:0] ok);
		sample_t s;
		s.temp_top       = temp_t'(a);
		s.temp_upper_mid = temp_t'(b);
		s.temp_mid       = temp_t'(c);
		s.temp_lower_mid = temp_t'(d);
		s.temp_bottom    = temp_t'(e);
		{s.top_ok, s.upper_mid_ok, s.mid_ok, s.lower_mid_ok, s.bottom_ok} = ok;
		return s;
	endfunction

	// random snapshot: a plausible stratified tank, uniform readings or raw bit patterns
	function automatic sample_t random_snapshot();
		sample_t s;
		int      t[SENSORS];
		int      base;
		int      style;
		int      flags;
		style = $urandom_range(9);
		base  = int'($urandom_range(1900)) - 400;
		for (int i = 0; i < SENSORS; i++) begin
			if (style == 0)
				t[i] = int'(temp_t'($urandom));
			else if (style <= 4)
				t[i] = base + int'($urandom_range(80)) - 40 - 20 * i;
			else
				t[i] = int'($urandom_range(1900)) - 400;
		end
		// sit on the alarm threshold now and then
		if ($urandom_range(5) == 0)
			t[0] = int'(board.regs.full_temp) + ALARM_MARGIN + int'($urandom_range(4)) - 2;
		flags = $urandom_range(9);
		s = snap(t[0], t[1], t[2], t[3], t[4],
			(flags == 0) ? 5'b00000 : (flags <= 3) ? 5'b11111 : 5'($urandom));
		return s;
	endfunction

	initial begin
		int e;

		arst_n <= 1'b0;
		put_snapshot('0, 1'b0);
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_ENABLE;
		cfg_ch.data  <= '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// disabled after reset: items are dropped
		send_snapshot(snap(500, 500, 500, 500, 500, 5'b11111));
		send_snapshot(snap(1500, 1500, 1500, 1500, 1500, 5'b11111));
		sample_ch.valid <= 1'b0;
		drain();

		// defaults, enabled: clamps, empty snapshots and the alarm edge
		apply_setting(1'b1, 300, 800, 500);
		send_snapshot(snap(300, 300, 300, 300, 300, 5'b11111));
		send_snapshot(snap(800, 800, 800, 800, 800, 5'b11111));
		send_snapshot(snap(550, 550, 550, 550, 550, 5'b11111));
		send_snapshot(snap(1500, 1500, 1500, 1500, 1500, 5'b11111));
		send_snapshot(snap(0, 0, 0, 0, 0, 5'b00000));          // alarm held
		send_snapshot(snap(880, 0, 0, 0, 0, 5'b10000));        // exactly at threshold
		send_snapshot(snap(881, 0, 0, 0, 0, 5'b10000));
		send_snapshot(snap(1500, 600, 600, 600, 600, 5'b01111)); // hot top but invalid
		send_snapshot(snap(-400, -400, -400, -400, -400, 5'b11111));
		send_snapshot(snap(-2048, -2048, -2048, -2048, -2048, 5'b11111));
		send_snapshot(snap(2047, 2047, 2047, 2047, 2047, 5'b11111));
		send_snapshot(snap(2047, 2047, 2047, 2047, 2047, 5'b00000));
		send_snapshot(snap(-400, 1500, -400, 1500, -400, 5'b01010));
		send_snapshot(snap(350, 400, 450, 500, 123, 5'b00111));
		send_snapshot(snap(301, 301, 301, 301, 301, 5'b00001));
		sample_ch.valid <= 1'b0;
		drain();

		// zero span
		apply_setting(1'b1, 800, 800, 10000);
		send_snapshot(snap(1000, 1000, 1000, 1000, 1000, 5'b11111));
		send_snapshot(snap(700, 720, 740, 760, 780, 5'b11111));
		sample_ch.valid <= 1'b0;
		drain();

		// negative span, empty tank volume
		apply_setting(1'b1, 900, 300, 0);
		send_snapshot(snap(1500, 1400, 1300, 1200, 1100, 5'b11111));
		sample_ch.valid <= 1'b0;
		drain();

		// widest span and largest volume pattern: energy saturates
		apply_setting(1'b1, -400, 1500, 16383);
		send_snapshot(snap(2047, 2047, 2047, 2047, 2047, 5'b11111));
		send_snapshot(snap(1500, 1500, 1500, 1500, 1500, 5'b11111));
		send_snapshot(snap(550, 550, 550, 550, 550, 5'b11111));
		send_snapshot(snap(0, 100, 0, 0, 0, 5'b11000));
		sample_ch.valid <= 1'b0;
		drain();

		// random phases, each with its own setting and idling pattern
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: apply_setting(1'b1, 300, 800, 500);
				1: apply_setting(1'b1, -400, 1500, 10000);
				2: apply_setting(1'b1, 1500, -400, 0);
				3: apply_setting(1'b1, int'($urandom_range(1900)) - 400,
					int'($urandom_range(1900)) - 400, int'($urandom_range(10000)));
				4: apply_setting(1'b1, -2048, 2047, 16383);
				5: apply_setting(1'b1, int'(temp_t'($urandom)), int'(temp_t'($urandom)),
					int'($urandom_range(16383)));
				6: begin
					e = int'($urandom_range(1900)) - 400;
					apply_setting(1'b1, e, e, int'($urandom_range(10000)));
				end
				default: apply_setting(1'b1, int'($urandom_range(600)) - 100,
					int'($urandom_range(900)) + 600, int'($urandom_range(10000)));
			endcase
			case (p % 4)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 83;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 83;
				end
				default: begin
					src_idle_pct   = 14;
					sink_stall_pct = 14;
				end
			endcase
			// the receiver goes quiet while items keep coming, so the block backs up
			if (p == 0)
				hold_req = ~hold_req;
			repeat (PHASE_ITEMS) send_snapshot(random_snapshot());
			sample_ch.valid <= 1'b0;
			drain();

			// a disabled burst midway: nothing comes out, alarm untouched
			if (p == 3) begin
				apply_setting(1'b0, 300, 800, 500);
				repeat (20) send_snapshot(random_snapshot());
				sample_ch.valid <= 1'b0;
				drain();
			end
		end

		if (board.errors == 0 && board.tank_readouts.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
